### rtl/sts_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Depends on nothing; every other file imports it.
package sts_pkg;

  // Table geometry and field widths.
  localparam int ADDR_W      = 10;
  localparam int TABLE_DEPTH = 1 << ADDR_W;
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int KEY_W       = 32;

  // Request operation codes.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } sts_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;    // store the request value at the request index
    logic start;    // load bounds and key for a new search
    logic read;     // read the table at the current midpoint
    logic compare;  // compare read data with the key and narrow the bounds
    logic emit;     // move the search outcome into the result register
  } sts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bounds_open;  // low bound still below the exclusive high bound
    logic hit;          // read data equals the key
    logic out_busy;     // result register holds a result that is not taken
  } sts_status_t;

endpackage

### rtl/sts_if.sv
// Handshake channel interfaces: search/write request, result and
// configuration write. Depends on sts_pkg.
interface sts_req_if;
  import sts_pkg::*;
  logic                    valid;
  logic                    ready;
  sts_op_t                 op;
  logic [ADDR_W-1:0]       index;
  logic signed [KEY_W-1:0] value;

  modport source (output valid, op, index, value, input ready);
  modport sink (input valid, op, index, value, output ready);
endinterface

interface sts_rsp_if;
  import sts_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

interface sts_cfg_if;
  import sts_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

### rtl/sts_datapath.sv
// Datapath: key table memory, search bounds, comparator, entry count
// register and result register. Depends on sts_pkg and sts_if.
module sts_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sts_pkg::sts_cmd_t               cmd,
  output sts_pkg::sts_status_t            status,
  input  logic [sts_pkg::ADDR_W-1:0]      req_index,
  input  logic signed [sts_pkg::KEY_W-1:0] req_value,
  sts_cfg_if.sink                         cfg,
  sts_rsp_if.source                       rsp
);
  import sts_pkg::*;

  logic signed [KEY_W-1:0] key_table [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rdata;
  logic signed [KEY_W-1:0] key;
  logic [COUNT_W-1:0]      entry_count;
  logic [COUNT_W-1:0]      count_sat;
  logic [COUNT_W-1:0]      lo;
  logic [COUNT_W-1:0]      bound_end;
  logic [COUNT_W:0]        mid_sum;
  logic [ADDR_W-1:0]       mid;
  logic [ADDR_W-1:0]       mid_q;
  logic                    hit_found;
  logic [ADDR_W-1:0]       hit_pos;
  logic                    out_valid;
  logic                    out_found;
  logic [ADDR_W-1:0]       out_pos;
  logic                    key_eq;
  logic                    key_gt;

  // Configuration is taken at any time; the user must change it only while idle, as the block does not enforce it.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid) begin
      entry_count <= cfg.entry_count;
    end
  end

  // Counts beyond the table depth cover the whole table.
  assign count_sat = (entry_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                           : entry_count;

  // Floor midpoint of lo and hi, where hi is bound_end - 1. Only used while
  // lo < bound_end, so the sum never underflows and the midpoint fits.
  assign mid_sum = {1'b0, lo} + {1'b0, bound_end} - (COUNT_W+1)'(1);
  assign mid     = mid_sum[ADDR_W:1];

  // Key table: one write port for table fills, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      key_table[req_index] <= req_value;
    end
    if (cmd.read) begin
      rdata <= key_table[mid];
      mid_q <= mid;
    end
  end

  assign key_eq = (key == rdata);
  assign key_gt = (key > rdata);

  // Search bounds and running outcome.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key       <= req_value;
      lo        <= '0;
      bound_end <= count_sat;
      hit_found <= 1'b0;
      hit_pos   <= '0;
    end else if (cmd.compare) begin
      if (key_eq) begin
        hit_found <= 1'b1;
        hit_pos   <= mid_q;
      end else if (key_gt) begin
        lo <= {1'b0, mid_q} + COUNT_W'(1);
      end else begin
        bound_end <= {1'b0, mid_q};
      end
    end
  end

  // Result register: holds the outcome until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found <= hit_found;
      out_pos   <= hit_pos;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.position = out_pos;

  assign status.bounds_open = (lo < bound_end);
  assign status.hit         = key_eq;
  assign status.out_busy    = out_valid && !rsp.ready;

endmodule

### rtl/sts_ctrl.sv
// Controller state machine: accepts requests and sequences the probe
// loop of a search. Depends on sts_pkg and sts_if.
module sts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  sts_req_if.sink              req,
  output sts_pkg::sts_cmd_t    cmd,
  input  sts_pkg::sts_status_t status
);
  import sts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_COMPARE,
    S_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Commands decoded from the current state and status.
  always_comb begin
    cmd         = '0;
    cmd.write   = accept && (req.op == OP_WRITE);
    cmd.start   = accept && (req.op == OP_SEARCH);
    cmd.read    = (state == S_CHECK) && status.bounds_open;
    cmd.compare = (state == S_COMPARE);
    cmd.emit    = (state == S_FINISH) && !status.out_busy;
  end

  // One probe is a table read followed by a compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && req.op == OP_SEARCH) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= status.bounds_open ? S_COMPARE : S_FINISH;
        end
        S_COMPARE: begin
          state <= status.hit ? S_FINISH : S_CHECK;
        end
        S_FINISH: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Depends on sts_pkg, sts_if, sts_ctrl and sts_datapath.
//
// The block keeps a 1024-entry table of signed 32-bit keys, filled by write
// requests, and answers search requests by binary search over positions 0
// to entry_count-1 (counts above 1024 cover the whole table). A write gives
// no result, and the next request is taken in the following cycle. A search
// keeps the request side busy through its probes, at most 11 for a full
// table: each probe reads the table's single registered read port and then
// compares the key and moves a bound. A finished result waits in an output
// register while new requests are taken; a search that finishes while an
// earlier result still waits there holds the request side until that result
// is taken. The table has no reset; searches must cover only written entries,
// and the table should be sorted ascending.
module sorted_table_binary_search (
  input logic       clk,
  input logic       rst,
  sts_req_if.sink   req,
  sts_cfg_if.sink   cfg,
  sts_rsp_if.source rsp
);
  import sts_pkg::*;

  sts_cmd_t    cmd;
  sts_status_t status;

  sts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status)
  );

  sts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_index (req.index),
    .req_value (req.value),
    .cfg       (cfg),
    .rsp       (rsp)
  );

endmodule

### rtl/sts_checker.sv
// Port-level checker for the sorted table binary search block, bound to
// the top level. Depends on sts_pkg.
module sts_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input sts_pkg::sts_op_t           req_op,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_found,
  input logic [sts_pkg::ADDR_W-1:0] rsp_position
);
  import sts_pkg::*;

  // A pending result holds until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
    else $error("result changed while stalled");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_position == '0)
    else $error("miss with nonzero position");

  // A search occupies the block for at least the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op == OP_SEARCH |=> !req_ready)
    else $error("request taken during a search");

  // A table write completes at once and the block stays ready.
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op == OP_WRITE |=> req_ready)
    else $error("block not ready after a write");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_op       (req.op),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.found),
  .rsp_position (rsp.position)
);

### bench/sorted_table_binary_search_test.sv
// Self-checking testbench for sorted_table_binary_search: a behavioral copy of the
// key table and its binary search predicts every search result, checked in order.
// Depends on sts_pkg and the channel interfaces in sts_if.
module sorted_table_binary_search_test;
  import sts_pkg::*;

  localparam int SETTLE_CYCLES  = 30;    // a full-table search plus output slack
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request, result or write
  localparam int HOLD_CYCLES    = 400;   // long result-side hold for back-pressure
  localparam int SMALL_SPAN     = 48;    // largest table refilled by a random phase

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } search_result_t;

  logic clk;
  logic rst;

  sts_req_if req ();
  sts_cfg_if cfg ();
  sts_rsp_if rsp ();

  sorted_table_binary_search dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cfg(cfg),
    .rsp(rsp)
  );

  // Shadow of the block state and the queue of pending search outcomes.
  logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [COUNT_W-1:0]      entry_count_model = '0;
  search_result_t          pending_outcomes [$];
  int                      mismatch_count = 0;
  int                      requests_sent = 0;
  int                      send_idle_pct = 28;
  int                      recv_idle_pct = 72;
  bit                      hold_output = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walk the same probe sequence as the block over the shadow table.
  function automatic search_result_t binary_search_outcome(logic signed [KEY_W-1:0] key);
    search_result_t outcome;
    int low;
    int high;
    int mid;
    outcome = '0;
    low = 0;
    high = (entry_count_model > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entry_count_model) - 1;
    while (low <= high && !outcome.found) begin
      mid = (low + high) / 2;
      if (key > table_keys[mid]) begin
        low = mid + 1;
      end else if (key < table_keys[mid]) begin
        high = mid - 1;
      end else begin
        outcome.found = 1'b1;
        outcome.position = mid[ADDR_W-1:0];
      end
    end
    return outcome;
  endfunction

  // Offer one request after random idle cycles and update the shadow state once it
  // is taken. Must be called at a rising edge; returns at the edge that takes it.
  task automatic send_request(sts_op_t op, logic [ADDR_W-1:0] index,
                              logic signed [KEY_W-1:0] value);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.index <= index;
    req.value <= value;
    do begin
      @(negedge clk);
      taken = req.ready;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
    if (op == OP_WRITE) begin
      table_keys[index] = value;
    end else begin
      pending_outcomes.push_back(binary_search_outcome(value));
    end
  endtask

  task automatic search_key(logic signed [KEY_W-1:0] key);
    send_request(OP_SEARCH, ADDR_W'($urandom), key);
  endtask

  // Write the entry count register; only called while the block is idle.
  task automatic write_entry_count(logic [COUNT_W-1:0] count);
    bit taken;
    cfg.valid       <= 1'b1;
    cfg.entry_count <= count;
    do begin
      @(negedge clk);
      taken = cfg.ready;
      @(posedge clk);
    end while (!taken);
    cfg.valid <= 1'b0;
    entry_count_model = count;
  endtask

  // Stop offering requests, wait for every pending result, then let the block drain.
  task automatic settle();
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write positions 0 to span-1 with random keys, ascending unless told otherwise.
  // Narrow ranges and the extremes make duplicate keys common.
  task automatic fill_table(int span, bit ascending);
    int fresh_keys [$];
    int pick;
    fresh_keys = {};
    for (int i = 0; i < span; i++) begin
      pick = $urandom_range(7);
      if (pick < 3) begin
        fresh_keys.push_back(int'($urandom));
      end else if (pick < 6) begin
        fresh_keys.push_back(int'($urandom_range(128)) - 64);
      end else if (pick == 6) begin
        fresh_keys.push_back(KEY_MIN);
      end else begin
        fresh_keys.push_back(KEY_MAX);
      end
    end
    if (ascending) fresh_keys.sort();
    for (int i = 0; i < span; i++) begin
      send_request(OP_WRITE, ADDR_W'(i), fresh_keys[i]);
    end
  endtask

  // Searches over the covered span, mostly for stored keys and their neighbors,
  // with a few stray writes that may break the ordering.
  task automatic search_burst(int searches, int span);
    int pick;
    logic signed [KEY_W-1:0] key;
    for (int i = 0; i < searches; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        send_request(OP_WRITE, ADDR_W'($urandom), $urandom);
      end
      key = (pick < 2) ? KEY_MIN : (pick < 3) ? KEY_MAX : $urandom;
      if (span > 0 && pick >= 3 && pick < 8) begin
        key = table_keys[$urandom_range(span - 1)];
      end else if (span > 0 && pick == 8) begin
        key = table_keys[$urandom_range(span - 1)] + (($urandom_range(1) == 1) ? 1 : -1);
      end
      search_key(key);
    end
  endtask

  // One random phase: pick a count, refill small tables, then search.
  task automatic run_table_phase();
    int pick;
    int count;
    int span;
    pick = $urandom_range(9);
    if (pick == 0) begin
      count = 0;
    end else if (pick == 1) begin
      count = $urandom_range(2047, SMALL_SPAN + 1);
    end else begin
      count = $urandom_range(SMALL_SPAN, 1);
    end
    span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    settle();
    write_entry_count(COUNT_W'(count));
    if (span > 0 && span <= SMALL_SPAN) fill_table(span, $urandom_range(5) != 0);
    search_burst($urandom_range(16, 6), span);
  endtask

  task automatic run_random_phases(int items);
    int start;
    start = requests_sent;
    while (requests_sent - start < items) run_table_phase();
  endtask

  // Searches with the reset count of zero must all miss.
  task automatic test_empty_table();
    search_key(0);
    search_key(KEY_MIN);
    search_key(KEY_MAX);
  endtask

  // One entry holding the most negative key.
  task automatic test_single_entry();
    settle();
    write_entry_count(COUNT_W'(1));
    send_request(OP_WRITE, '0, KEY_MIN);
    search_key(KEY_MIN);
    search_key(KEY_MAX);
    search_key(0);
  endtask

  // Both key extremes and a duplicated key in a five-entry table.
  task automatic test_extremes_and_duplicates();
    settle();
    write_entry_count(COUNT_W'(5));
    send_request(OP_WRITE, ADDR_W'(0), KEY_MIN);
    send_request(OP_WRITE, ADDR_W'(1), -7);
    send_request(OP_WRITE, ADDR_W'(2), 9);
    send_request(OP_WRITE, ADDR_W'(3), 9);
    send_request(OP_WRITE, ADDR_W'(4), KEY_MAX);
    search_key(9);
    search_key(KEY_MAX);
    search_key(KEY_MIN);
    search_key(8);
  endtask

  // The largest key in the middle breaks the order; the probes still run the same way.
  task automatic test_unsorted_table();
    settle();
    write_entry_count(COUNT_W'(3));
    send_request(OP_WRITE, ADDR_W'(1), KEY_MAX);
    search_key(9);
    search_key(KEY_MAX);
    search_key(-7);
  endtask

  // Fill every position, search the full table, then counts beyond the depth.
  task automatic test_full_table();
    settle();
    write_entry_count(COUNT_W'(TABLE_DEPTH));
    fill_table(TABLE_DEPTH, 1'b1);
    search_burst(30, TABLE_DEPTH);
    settle();
    write_entry_count('1);
    search_burst(10, TABLE_DEPTH);
  endtask

  // Hold the result side for a long stretch while searches keep coming.
  task automatic test_back_pressure();
    settle();
    write_entry_count(COUNT_W'(TABLE_DEPTH));
    hold_output = 1'b1;
    search_burst(12, TABLE_DEPTH);
  endtask

  // Result side: random stalls, with one long hold when a test asks for it.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        repeat (HOLD_CYCLES) begin
          rsp.ready <= 1'b0;
          @(posedge clk);
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result taken from the block with the oldest pending outcome.
  always @(negedge clk) begin
    search_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: found %0b position %0d",
                 $time, rsp.found, rsp.position);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.found !== want.found) begin
          $display("%0t: found mismatch: expected %0b actual %0b",
                   $time, want.found, rsp.found);
          mismatch_count++;
        end
        if (rsp.position !== want.position) begin
          $display("%0t: position mismatch: expected %0d actual %0d",
                   $time, want.position, rsp.position);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing has been accepted for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.op          <= OP_WRITE;
    req.index       <= '0;
    req.value       <= '0;
    cfg.valid       <= 1'b0;
    cfg.entry_count <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_single_entry();
    test_extremes_and_duplicates();
    test_unsorted_table();

    // Sender idles lightly, receiver heavily.
    test_full_table();
    run_random_phases(30);

    // Sender idles heavily, receiver lightly.
    settle();
    send_idle_pct = 72;
    recv_idle_pct = 28;
    run_random_phases(120);

    // No idling on either side.
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_back_pressure();
    run_random_phases(120);

    settle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_datapath.sv
rtl/sts_ctrl.sv
rtl/sorted_table_binary_search.sv
rtl/sts_checker.sv
bench/sorted_table_binary_search_test.sv
